### rtl/utf8vt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8vt_pkg: shared types and constants for the UTF-8 validating transcoder
// Code point limits, UTF-16 surrogate bases and the result entry layout.
// ----------------------------------------------------------------------------
package utf8vt_pkg;

    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST    = 21'h00D800;
    localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
    localparam logic [20:0] BMP_LAST      = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [20:0] TWO_BYTE_MIN  = 21'h000080;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // Depth of the result queue; a byte may push two entries.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [20:0] code_unit;
        logic        unit_valid;
        logic        error;
        logic        run_last;
        logic        string_end;
    } result_t;

endpackage : utf8vt_pkg
`default_nettype wire

### rtl/utf8_validating_transcoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validating_transcoder_core: UTF-8 to UTF-16 / UTF-32 transcoder
// Validates a byte stream, emits code units or points, flags bad strings.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  input     in_valid, in_ready, in_byte, final_byte   in  (ready out)
//  result    out_valid, out_ready, code_unit,          out (ready in)
//            unit_valid, error, run_last, string_end
//  config    cfg_we, cfg_wdata (output_utf32)          in
//
//  Each byte beat is decoded in the cycle it is accepted and its zero, one or
//  two results land in a four-entry result queue; one result leaves per cycle while out_ready is high.
//  A byte is taken every cycle while the queue has room for two entries, so
//  the input rate is one byte per cycle until surrogate pairs fill the queue.
//  Reset clears the sequence state, the discard flag, the mode and the queue.
//  A stalled consumer holds in_ready low once fewer than two entries are free.
//
module utf8_validating_transcoder_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [20:0]      code_unit,
    output logic             unit_valid,
    output logic             error,
    output logic             run_last,
    output logic             string_end
);
    import utf8vt_pkg::*;

    logic                 output_utf32_reg;
    logic [1:0]           bytes_remaining_reg, bytes_remaining_next;
    logic [2:0]           seq_len_reg, seq_len_next;
    logic [20:0]          acc_reg, acc_next;
    logic                 discarding_reg, discarding_next;

    result_t              queue_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg;

    logic                 in_acc, out_acc;
    logic [1:0]           n_res;
    result_t              res0, res1;

    // Decode of one byte against the current sequence state.
    logic [20:0] cp;
    logic [19:0] supp;
    logic        bad_point;
    logic        fail;
    logic        emit;

    always_comb
    begin
        bytes_remaining_next = bytes_remaining_reg;
        seq_len_next         = seq_len_reg;
        acc_next             = acc_reg;
        discarding_next      = discarding_reg;
        fail                 = 1'b0;
        emit                 = 1'b0;
        cp                   = {13'd0, in_byte};
        n_res                = 2'd0;
        res0                 = '0;
        res1                 = '0;
        bad_point            = 1'b0;

        if (discarding_reg)
        begin
            if (final_byte)
            begin
                discarding_next = 1'b0;
                n_res           = 2'd1;
                res0            = '{code_unit: 21'd0, unit_valid: 1'b0, error: 1'b1,
                                    run_last: 1'b1, string_end: 1'b1};
            end
        end
        else if (bytes_remaining_reg == 2'd0)
        begin
            if (!in_byte[7])
            begin
                emit = 1'b1;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                acc_next             = {16'd0, in_byte[4:0]};
                seq_len_next         = SEQ_LEN_2;
                bytes_remaining_next = 2'd1;
                fail                 = final_byte;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                acc_next             = {17'd0, in_byte[3:0]};
                seq_len_next         = SEQ_LEN_3;
                bytes_remaining_next = 2'd2;
                fail                 = final_byte;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                acc_next             = {18'd0, in_byte[2:0]};
                seq_len_next         = SEQ_LEN_4;
                bytes_remaining_next = 2'd3;
                fail                 = final_byte;
            end
            else
            begin
                fail = 1'b1;
            end
        end
        else if (in_byte[7:6] != 2'b10)
        begin
            fail = 1'b1;
        end
        else
        begin
            cp                   = {acc_reg[14:0], in_byte[5:0]};
            acc_next             = cp;
            bytes_remaining_next = bytes_remaining_reg - 2'd1;
            if (bytes_remaining_reg != 2'd1)
            begin
                fail = final_byte;
            end
            else
            begin
                bad_point = (seq_len_reg == SEQ_LEN_2 && cp < TWO_BYTE_MIN)
                         || (seq_len_reg == SEQ_LEN_3 && cp < THREE_BYTE_MIN)
                         || (seq_len_reg == SEQ_LEN_4 && cp < SUPP_BASE)
                         || (cp > CP_MAX)
                         || (cp >= SURR_FIRST && cp <= SURR_LAST);
                fail = bad_point;
                emit = !bad_point;
            end
        end

        supp = 20'(cp - SUPP_BASE);

        if (fail)
        begin
            bytes_remaining_next = 2'd0;
            seq_len_next         = 3'd0;
            acc_next             = 21'd0;
            discarding_next      = !final_byte;
            n_res                = 2'd1;
            res0                 = '{code_unit: 21'd0, unit_valid: 1'b0, error: 1'b1,
                                     run_last: 1'b1, string_end: final_byte};
        end
        else if (emit)
        begin
            bytes_remaining_next = 2'd0;
            seq_len_next         = 3'd0;
            acc_next             = 21'd0;
            if (output_utf32_reg || cp <= BMP_LAST)
            begin
                n_res = 2'd1;
                res0  = '{code_unit: cp, unit_valid: 1'b1, error: 1'b0,
                          run_last: 1'b1, string_end: final_byte};
            end
            else
            begin
                // Points above the BMP split into a high and a low surrogate.
                n_res = 2'd2;
                res0  = '{code_unit: {5'd0, HIGH_SURR_BASE + {6'd0, supp[19:10]}},
                          unit_valid: 1'b1, error: 1'b0,
                          run_last: 1'b0, string_end: 1'b0};
                res1  = '{code_unit: {5'd0, LOW_SURR_BASE + {6'd0, supp[9:0]}},
                          unit_valid: 1'b1, error: 1'b0,
                          run_last: 1'b1, string_end: final_byte};
            end
        end
    end

    assign in_ready  = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && out_ready;

    assign code_unit  = queue_reg[rd_ptr_reg].code_unit;
    assign unit_valid = queue_reg[rd_ptr_reg].unit_valid;
    assign error      = queue_reg[rd_ptr_reg].error;
    assign run_last   = queue_reg[rd_ptr_reg].run_last;
    assign string_end = queue_reg[rd_ptr_reg].string_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_utf32_reg    <= 1'b0;
            bytes_remaining_reg <= 2'd0;
            seq_len_reg         <= 3'd0;
            acc_reg             <= 21'd0;
            discarding_reg      <= 1'b0;
            wr_ptr_reg          <= '0;
            rd_ptr_reg          <= '0;
            count_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                output_utf32_reg <= cfg_wdata;
            end
            if (in_acc)
            begin
                bytes_remaining_reg <= bytes_remaining_next;
                seq_len_reg         <= seq_len_next;
                acc_reg             <= acc_next;
                discarding_reg      <= discarding_next;
                wr_ptr_reg          <= wr_ptr_reg + RES_PTR_W'(n_res);
            end
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_reg + (in_acc ? RES_CNT_W'(n_res) : '0)
                                   - (out_acc ? RES_CNT_W'(1) : '0);
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_acc && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + RES_PTR_W'(1)] <= res1;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count exceeds its depth");

    a_error_no_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> !unit_valid && code_unit == 21'd0 && run_last)
        else $error("error beat carries a code unit");

    a_high_surr_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !run_last |=> out_valid && unit_valid && run_last && !error)
        else $error("high surrogate not followed by its low unit");

    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> bytes_remaining_reg == 2'd0 && seq_len_reg == 3'd0)
        else $error("sequence state held while discarding");
`endif

endmodule : utf8_validating_transcoder_core
`default_nettype wire

### bench/tb_utf8_validating_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_validating_transcoder_core: self-checking bench for the transcoder
// Drives directed and random UTF-8 strings under both output modes, predicts
// every code unit and error beat, and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_utf8_validating_transcoder_core;
    import utf8vt_pkg::*;

    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    // Chance in percent of starting an idle stretch, per byte sent and per cycle on the result side.
    localparam int IDLE_PERCENT   = 6;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_COUNT = 27;

    // Expected beats that the table spells out directly.
    localparam result_t RES_NONE    = '0;
    localparam result_t RES_ERR_MID = '{code_unit: 21'h0, unit_valid: 1'b0, error: 1'b1,
                                        run_last: 1'b1, string_end: 1'b0};
    localparam result_t RES_ERR_END = '{code_unit: 21'h0, unit_valid: 1'b0, error: 1'b1,
                                        run_last: 1'b1, string_end: 1'b1};
    localparam result_t RES_NUL_MID = '{code_unit: 21'h0, unit_valid: 1'b1, error: 1'b0,
                                        run_last: 1'b1, string_end: 1'b0};
    localparam result_t RES_7F_END  = '{code_unit: 21'h7F, unit_valid: 1'b1, error: 1'b0,
                                        run_last: 1'b1, string_end: 1'b1};

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_string;
        logic       typed;
        result_t    want;
    } byte_row_t;

    typedef enum int {
        CK_ASCII, CK_TWO, CK_THREE, CK_FOUR, CK_RANDOM, CK_OVERLONG,
        CK_SURROGATE, CK_TOO_LARGE, CK_TRUNCATED, CK_BAD_CONT, CK_BAD_LEAD
    } char_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [20:0] code_unit;
    logic        unit_valid;
    logic        error;
    logic        run_last;
    logic        string_end;

    // Shadow of the decoder state.
    logic        mode_utf32 = MODE_UTF16;
    logic [1:0]  cont_left = '0;
    logic [2:0]  seq_len = '0;
    logic [20:0] point_acc = '0;
    logic        dropping = 1'b0;

    result_t     expected_units [$];
    logic [7:0]  string_bytes [$];
    byte_row_t   directed_rows [DIRECTED_COUNT];

    int          error_count = 0;
    logic        quiet = 1'b0;
    int          hold_req_seq = 0;
    int          hold_seen = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    utf8_validating_transcoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .unit_valid (unit_valid),
        .error      (error),
        .run_last   (run_last),
        .string_end (string_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_unit(logic [20:0] unit, logic valid, logic err,
                                      logic last, logic fin);
        result_t r;
        r.code_unit  = unit;
        r.unit_valid = valid;
        r.error      = err;
        r.run_last   = last;
        r.string_end = fin;
        expected_units = {expected_units, r};
    endfunction

    function automatic void clear_sequence();
        cont_left = '0;
        seq_len   = '0;
        point_acc = '0;
    endfunction

    function automatic void flag_bad_string(logic fin);
        clear_sequence();
        dropping = !fin;
        push_unit(21'h0, 1'b0, 1'b1, 1'b1, fin);
    endfunction

    function automatic void emit_point(logic [20:0] cp, logic fin);
        logic [20:0] offset;
        clear_sequence();
        if (mode_utf32 || cp <= BMP_LAST)
        begin
            push_unit(cp, 1'b1, 1'b0, 1'b1, fin);
        end
        else
        begin
            offset = cp - SUPP_BASE;
            push_unit(21'(HIGH_SURR_BASE) + 21'(offset[19:10]), 1'b1, 1'b0, 1'b0, 1'b0);
            push_unit(21'(LOW_SURR_BASE) + 21'(offset[9:0]), 1'b1, 1'b0, 1'b1, fin);
        end
    endfunction

    // Advances the shadow decoder by one accepted byte and queues its beats.
    function automatic void transcode_byte(logic [7:0] b, logic fin);
        logic [20:0] cp;
        logic        bad;
        if (dropping)
        begin
            if (fin)
            begin
                dropping = 1'b0;
                clear_sequence();
                push_unit(21'h0, 1'b0, 1'b1, 1'b1, 1'b1);
            end
            return;
        end
        if (cont_left == 2'd0)
        begin
            if (!b[7])
            begin
                emit_point(21'(b), fin);
                return;
            end
            if (b[7:5] == 3'b110)
            begin
                point_acc = 21'(b[4:0]);
                seq_len   = SEQ_LEN_2;
            end
            else if (b[7:4] == 4'b1110)
            begin
                point_acc = 21'(b[3:0]);
                seq_len   = SEQ_LEN_3;
            end
            else if (b[7:3] == 5'b11110)
            begin
                point_acc = 21'(b[2:0]);
                seq_len   = SEQ_LEN_4;
            end
            else
            begin
                flag_bad_string(fin);
                return;
            end
            cont_left = 2'(seq_len - 3'd1);
            if (fin)
                flag_bad_string(fin);
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            flag_bad_string(fin);
            return;
        end
        point_acc = {point_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0)
        begin
            if (fin)
                flag_bad_string(fin);
            return;
        end
        cp  = point_acc;
        bad = (seq_len == SEQ_LEN_2 && cp < TWO_BYTE_MIN) ||
              (seq_len == SEQ_LEN_3 && cp < THREE_BYTE_MIN) ||
              (seq_len == SEQ_LEN_4 && cp < SUPP_BASE) ||
              cp > CP_MAX || (cp >= SURR_FIRST && cp <= SURR_LAST);
        if (bad)
            flag_bad_string(fin);
        else
            emit_point(cp, fin);
    endfunction

    function automatic void report_field(string name, logic [20:0] want, logic [20:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_beat(result_t got);
        result_t want;
        if (expected_units.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual %0h/%b%b%b%b",
                     $time, got.code_unit, got.unit_valid, got.error, got.run_last,
                     got.string_end);
            error_count++;
            return;
        end
        want = expected_units.pop_front();
        report_field("code_unit", want.code_unit, got.code_unit);
        report_field("unit_valid", 21'(want.unit_valid), 21'(got.unit_valid));
        report_field("error", 21'(want.error), 21'(got.error));
        report_field("run_last", 21'(want.run_last), 21'(got.run_last));
        report_field("string_end", 21'(want.string_end), 21'(got.string_end));
    endfunction

    // Result side: checks beats and throttles out_ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_beat('{code_unit, unit_valid, error, run_last, string_end});
            if (hold_req_seq != hold_seen)
            begin
                hold_seen  = hold_req_seq;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < IDLE_PERCENT)
            begin
                stall_left = $urandom_range(2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d beats outstanding",
                         $time, expected_units.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input result_t want);
        int gap;
        int n0;
        gap = 0;
        if (!quiet && $urandom_range(99) < IDLE_PERCENT)
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n0 = expected_units.size();
        transcode_byte(b, fin);
        if (typed)
        begin
            while (expected_units.size() > n0)
                void'(expected_units.pop_back());
            expected_units = {expected_units, want};
        end
    endtask

    // Stops offering bytes until every expected beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mode_utf32 = mode;
    endtask

    function automatic void append_byte(logic [7:0] b);
        string_bytes = {string_bytes, b};
    endfunction

    function automatic void encode_point(logic [20:0] cp, int len);
        case (len)
            1: append_byte({1'b0, cp[6:0]});
            2:
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] valid_point(int len);
        logic [20:0] cp;
        case (len)
            2: cp = 21'($urandom_range(32'h7FF, 32'h80));
            3:
            begin
                cp = 21'($urandom_range(32'hFFFF, 32'h800));
                if (cp >= SURR_FIRST && cp <= SURR_LAST)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
        return cp;
    endfunction

    function automatic char_kind_t pick_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 28) return CK_ASCII;
        if (roll < 43) return CK_TWO;
        if (roll < 58) return CK_THREE;
        if (roll < 78) return CK_FOUR;
        case ($urandom_range(6))
            0: return CK_RANDOM;
            1: return CK_OVERLONG;
            2: return CK_SURROGATE;
            3: return CK_TOO_LARGE;
            4: return CK_TRUNCATED;
            5: return CK_BAD_CONT;
            default: return CK_BAD_LEAD;
        endcase
    endfunction

    // Appends one character, mostly well formed, sometimes broken on purpose.
    function automatic void add_char();
        int         len;
        int         drop;
        int         pos;
        logic [7:0] junk;
        case (pick_kind())
            CK_ASCII:     encode_point(21'($urandom_range(127)), 1);
            CK_TWO:       encode_point(valid_point(2), 2);
            CK_THREE:     encode_point(valid_point(3), 3);
            CK_FOUR:      encode_point(valid_point(4), 4);
            CK_RANDOM:    append_byte(8'($urandom_range(255)));
            CK_OVERLONG:
            begin
                len = $urandom_range(4, 2);
                case (len)
                    2: encode_point(21'($urandom_range(32'h7F)), 2);
                    3: encode_point(21'($urandom_range(32'h7FF)), 3);
                    default: encode_point(21'($urandom_range(32'hFFFF)), 4);
                endcase
            end
            CK_SURROGATE: encode_point(21'($urandom_range(32'hDFFF, 32'hD800)), 3);
            CK_TOO_LARGE: encode_point(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
            CK_TRUNCATED:
            begin
                len = $urandom_range(4, 2);
                encode_point(valid_point(len), len);
                drop = $urandom_range(len - 1, 1);
                repeat (drop) void'(string_bytes.pop_back());
            end
            CK_BAD_CONT:
            begin
                len = $urandom_range(4, 2);
                encode_point(valid_point(len), len);
                pos  = string_bytes.size() - $urandom_range(len - 1, 1);
                junk = 8'($urandom_range(255));
                if (junk[7:6] == 2'b10)
                    junk[6] = 1'b1;
                string_bytes[pos] = junk;
            end
            default:
            begin
                if ($urandom_range(1))
                    append_byte(8'($urandom_range(255, 248)));
                else
                    append_byte(8'($urandom_range(191, 128)));
            end
        endcase
    endfunction

    task automatic random_phase(input int n_items, input int hold_at, input int quiet_items);
        int  count;
        bit  held;
        int  nchars;
        count = 0;
        held  = 1'b0;
        while (count < n_items)
        begin
            string_bytes.delete();
            nchars = $urandom_range(6, 1);
            repeat (nchars) add_char();
            foreach (string_bytes[i])
            begin
                quiet = (count < quiet_items);
                if (!held && hold_at >= 0 && count >= hold_at)
                begin
                    held = 1'b1;
                    hold_req_seq++;
                end
                send_byte(string_bytes[i], i == string_bytes.size() - 1, 1'b0, RES_NONE);
                count++;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, RES_NUL_MID},   // smallest byte
            '{8'h7F, 1'b1, 1'b1, RES_7F_END},    // largest ASCII byte, string end
            '{8'h80, 1'b0, 1'b1, RES_ERR_MID},   // stray continuation as lead
            '{8'h41, 1'b1, 1'b1, RES_ERR_END},   // final byte while dropping
            '{8'hF8, 1'b1, 1'b1, RES_ERR_END},   // five-byte lead is invalid
            '{8'hC2, 1'b0, 1'b0, RES_NONE},
            '{8'h80, 1'b0, 1'b0, RES_NONE},      // U+0080
            '{8'hC1, 1'b0, 1'b0, RES_NONE},
            '{8'hBF, 1'b1, 1'b1, RES_ERR_END},   // overlong two-byte form
            '{8'hE0, 1'b0, 1'b0, RES_NONE},
            '{8'hA0, 1'b0, 1'b0, RES_NONE},
            '{8'h80, 1'b0, 1'b0, RES_NONE},      // U+0800
            '{8'hED, 1'b0, 1'b0, RES_NONE},
            '{8'hA0, 1'b0, 1'b0, RES_NONE},
            '{8'h80, 1'b1, 1'b1, RES_ERR_END},   // surrogate code point
            '{8'hF0, 1'b0, 1'b0, RES_NONE},
            '{8'h90, 1'b0, 1'b0, RES_NONE},
            '{8'h80, 1'b0, 1'b0, RES_NONE},
            '{8'h80, 1'b0, 1'b0, RES_NONE},      // U+10000, first pair
            '{8'hF4, 1'b0, 1'b0, RES_NONE},
            '{8'h8F, 1'b0, 1'b0, RES_NONE},
            '{8'hBF, 1'b0, 1'b0, RES_NONE},
            '{8'hBF, 1'b1, 1'b0, RES_NONE},      // U+10FFFF, last pair
            '{8'hE2, 1'b1, 1'b1, RES_ERR_END},   // lead on the final byte
            '{8'hC3, 1'b0, 1'b0, RES_NONE},
            '{8'h41, 1'b0, 1'b1, RES_ERR_MID},   // bad continuation
            '{8'hFF, 1'b1, 1'b1, RES_ERR_END}    // ends the dropped string
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(MODE_UTF16);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last_of_string,
                      directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // A long receiver hold-off starts once 40 bytes of this phase have been sent.
        write_mode(MODE_UTF32);
        random_phase(160, 40, 0);
        drain_results();

        write_mode(MODE_UTF16);
        random_phase(180, -1, 90);
        drain_results();

        write_mode(MODE_UTF32);
        random_phase(80, -1, 0);
        drain_results();

        write_mode(MODE_UTF16);
        random_phase(80, 30, 0);
        drain_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
